/* hw/rtl/cslm_pkg.sv */
`default_nettype none
package cslm_pkg;

    localparam int NCNT = 11;
    localparam int NLVL = 5;
    localparam int CW   = 32;
    localparam int DW   = 16;
    localparam int GW   = 34;
    localparam int SW   = 35;
    localparam int JW   = 36;
    localparam int NW   = 45;
    localparam int QW   = 9;

    localparam logic [1:0] CFG_GFX_SPLIT    = 2'd0;
    localparam logic [1:0] CFG_DECAY_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_CPU_COUNT    = 2'd2;

    typedef logic [NCNT-1:0][CW-1:0] cnt_arr_t;
    typedef logic [NLVL-1:0][NW-1:0] num_arr_t;
    typedef logic [NLVL-1:0][7:0] lvl_arr_t;

    typedef struct packed {
        logic rd_en;
        logic mul_en;
        logic upd_en;
        logic wr_en;
        logic primed;
    } lane_ctrl_t;

    typedef struct packed {
        logic grp_en;
        logic acc_en;
        logic num_en;
    } merge_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/cpu_load_smoothing_meter.sv */
// CPU load smoothing meter.
// Each item on the s_ channel is one sample of eleven cumulative tick
// counters of one CPU. The block keeps the previous sample and a smoothed
// value per counter and CPU in on-chip memories, one lane per counter, and
// returns one item of five cumulative load levels (0 to 255) per sample
// on the m_ channel. m_tlast marks the CPU whose index is cpu_count - 1.
// The cfg_ channel writes the gfx split flag, the decay weight and
// cpu_count by index; it is always ready. The user must write it only
// while no sample is in flight; the block itself does not enforce this.
// A sample is accepted only while the block is idle. The result item is
// valid in the same cycle as the block is ready again, so it is through
// with one sample before it takes the next. The five bit-serial level
// dividers run side by side.
// The result sits in an output register; while the receiver stalls, the
// block finishes the next sample and then waits to hand it over.
// Reset clears the per-CPU primed flags and loads the register defaults;
// the first sample of each CPU after reset only records its counters.
`default_nettype none
module cpu_load_smoothing_meter
    import cslm_pkg::*;
#(
    parameter int MAX_CPUS = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cpu_index, idle, user, kernel, waitstate, sxbrk, intr, io_wait,
    // swap_wait, pio_wait, gfx_fifo, gfx_ctx ticks, zero pad
    input  wire logic [359:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cpu_index_out, user, sys, intr, io, gfx levels, zero pad
    output logic      [47:0]  m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int XW = (AW > 6) ? AW : 6;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_GRP  = 4'd3;
    localparam logic [3:0] ST_ACC  = 4'd4;
    localparam logic [3:0] ST_NUM  = 4'd5;
    localparam logic [3:0] ST_DLD  = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [3:0]          bit_reg;
    logic                gfx_split_reg;
    logic [DW-1:0]       decay_reg;
    logic [6:0]          cpu_count_reg;
    logic [MAX_CPUS-1:0] primed_reg;
    logic [5:0]          cpu_reg;
    cnt_arr_t            ticks_reg;
    logic                primed_hit_reg;
    logic                in_range_reg;
    logic                m_tvalid_reg;
    logic [47:0]         m_tdata_reg;
    logic                m_tlast_reg;

    logic                accept;
    logic [XW-1:0]       cpu_in_x;
    logic [XW-1:0]       cpu_x;
    logic                in_range_in;
    logic [AW-1:0]       addr_in;
    logic [AW-1:0]       addr_cur;
    logic [AW-1:0]       lane_addr;
    logic                out_load;
    lane_ctrl_t          lane_ctrl;
    merge_ctrl_t         merge_ctrl;
    div_ctrl_t           div_ctrl;
    cnt_arr_t            avg;
    num_arr_t            num;
    logic [SW-1:0]       den;
    lvl_arr_t            lvl;
    lvl_arr_t            lvl_out;

    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign cpu_in_x    = XW'(s_tdata[5:0]);
    assign cpu_x       = XW'(cpu_reg);
    assign in_range_in = 32'(cpu_in_x) < MAX_CPUS;
    assign addr_in     = cpu_in_x[AW-1:0];
    assign addr_cur    = cpu_x[AW-1:0];
    assign lane_addr   = (state_reg == ST_IDLE) ? addr_in : addr_cur;
    assign out_load    = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign lane_ctrl.rd_en  = accept;
    assign lane_ctrl.mul_en = (state_reg == ST_RD);
    assign lane_ctrl.upd_en = (state_reg == ST_MUL);
    assign lane_ctrl.wr_en  = (state_reg == ST_MUL) && in_range_reg;
    assign lane_ctrl.primed = primed_hit_reg;

    assign merge_ctrl.grp_en = (state_reg == ST_GRP);
    assign merge_ctrl.acc_en = (state_reg == ST_ACC);
    assign merge_ctrl.num_en = (state_reg == ST_NUM);

    assign div_ctrl.load = (state_reg == ST_DLD);
    assign div_ctrl.step = (state_reg == ST_DIV);

    for (genvar g = 0; g < NCNT; g++) begin : g_lane
        cslm_lane #(.MAX_CPUS(MAX_CPUS)) u_lane (
            .aclk(aclk), .ctrl(lane_ctrl), .addr(lane_addr),
            .cur(ticks_reg[g]), .decay(decay_reg), .avg_out(avg[g])
        );
    end

    cslm_merge u_merge (
        .aclk(aclk), .ctrl(merge_ctrl), .avg(avg),
        .gfx_split(gfx_split_reg), .num(num), .den(den)
    );

    for (genvar g = 0; g < NLVL; g++) begin : g_div
        cslm_div u_div (
            .aclk(aclk), .ctrl(div_ctrl), .num(num[g]), .den(den), .level(lvl[g])
        );
    end

    always_comb begin
        lvl_out = lvl;
        if (!gfx_split_reg) begin
            lvl_out[4] = 8'd0;
        end
        if (!in_range_reg) begin
            lvl_out = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RD;
            ST_RD:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_GRP;
            ST_GRP:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_NUM;
            ST_NUM:  state_next = ST_DLD;
            ST_DLD:  state_next = ST_DIV;
            ST_DIV:  if (bit_reg == 4'd0) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            bit_reg         <= '0;
            gfx_split_reg   <= 1'b0;
            decay_reg       <= 16'd16384;
            cpu_count_reg   <= 7'd1;
            primed_reg      <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DLD) begin
                bit_reg <= 4'(QW - 1);
            end else if (state_reg == ST_DIV) begin
                bit_reg <= bit_reg - 4'd1;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_GFX_SPLIT:    gfx_split_reg <= cfg_data[0];
                    CFG_DECAY_WEIGHT: decay_reg     <= cfg_data;
                    CFG_CPU_COUNT:    cpu_count_reg <= cfg_data[6:0];
                    default:          ;
                endcase
            end
            if (lane_ctrl.wr_en) begin
                primed_reg[addr_cur] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cpu_reg        <= s_tdata[5:0];
            in_range_reg   <= in_range_in;
            primed_hit_reg <= in_range_in && primed_reg[addr_in];
            for (int k = 0; k < NCNT; k++) begin
                ticks_reg[k] <= s_tdata[6 + k*CW +: CW];
            end
        end
        if (out_load) begin
            m_tdata_reg <= {2'b00, lvl_out[4], lvl_out[3], lvl_out[2], lvl_out[1],
                            lvl_out[0], cpu_reg};
            m_tlast_reg <= ({1'b0, cpu_reg} + 7'd1) == cpu_count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_RD)
        else $error("accepted item did not start the lane read");
    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && bit_reg == 4'd0) |=> state_reg == ST_OUT)
        else $error("divider did not finish after nine steps");
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !in_range_reg) |=> m_tdata[45:6] == '0)
        else $error("levels of an out-of-range CPU are not zero");
    a_primed_set: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_ctrl.wr_en |=> primed_reg[$past(addr_cur)])
        else $error("primed flag not set after a sample was stored");
`endif
endmodule
`default_nettype wire

/* hw/rtl/cslm_ram.sv */
`default_nettype none
module cslm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

/* hw/rtl/cslm_lane.sv */
`default_nettype none
module cslm_lane
    import cslm_pkg::*;
#(
    parameter int MAX_CPUS = 64
) (
    input  wire logic                                         aclk,
    input  wire lane_ctrl_t                                   ctrl,
    input  wire logic [(MAX_CPUS > 1 ? $clog2(MAX_CPUS) : 1)-1:0] addr,
    input  wire logic [CW-1:0]                                cur,
    input  wire logic [DW-1:0]                                decay,
    output logic      [CW-1:0]                                avg_out
);
    logic [CW-1:0]   prev_rd;
    logic [CW-1:0]   avg_rd;
    logic [CW-1:0]   avg_eff;
    logic [CW-1:0]   delta;
    logic [DW:0]     weight;
    logic [47:0]     prod_a_reg;
    logic [48:0]     prod_b_reg;
    logic [48:0]     acc;
    logic [CW-1:0]   avg_next;
    logic [CW-1:0]   avg_reg;

    cslm_ram #(.WIDTH(CW), .DEPTH(MAX_CPUS)) u_prev (
        .aclk(aclk), .we(ctrl.wr_en), .waddr(addr), .wdata(cur),
        .re(ctrl.rd_en), .raddr(addr), .rdata(prev_rd)
    );

    cslm_ram #(.WIDTH(CW), .DEPTH(MAX_CPUS)) u_avg (
        .aclk(aclk), .we(ctrl.wr_en), .waddr(addr), .wdata(avg_next),
        .re(ctrl.rd_en), .raddr(addr), .rdata(avg_rd)
    );

    // The averages of a CPU that is not primed are stale; they count as zero
    // and are stored as zero by its first sample.
    assign avg_eff  = ctrl.primed ? avg_rd : '0;
    assign delta    = cur - prev_rd;
    assign weight   = 17'h10000 - {1'b0, decay};
    assign acc      = {1'b0, prod_a_reg} + prod_b_reg;
    assign avg_next = ctrl.primed ? acc[47:16] : avg_eff;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_a_reg <= avg_eff * decay;
            prod_b_reg <= delta * weight;
        end
        if (ctrl.upd_en) begin
            avg_reg <= avg_next;
        end
    end

    assign avg_out = avg_reg;
endmodule
`default_nettype wire

/* hw/rtl/cslm_merge.sv */
`default_nettype none
module cslm_merge
    import cslm_pkg::*;
(
    input  wire logic        aclk,
    input  wire merge_ctrl_t ctrl,
    input  wire cnt_arr_t    avg,
    input  wire logic        gfx_split,
    output num_arr_t         num,
    output logic [SW-1:0]    den
);
    logic [GW-1:0] g_rest_reg, g_user_reg, g_sys_reg, g_intr_reg, g_io_reg, g_gfx_reg;
    logic [SW-1:0] sum_raw;
    logic [SW-1:0] sum_reg;
    logic [JW-1:0] j_next [NLVL];
    logic [JW-1:0] j_reg [NLVL];
    logic [JW-1:0] io_add, gfx_add;
    num_arr_t      num_reg;

    assign sum_raw = SW'(g_rest_reg) + SW'(g_user_reg) + SW'(g_sys_reg) + SW'(g_intr_reg);
    assign io_add  = JW'(g_io_reg) + (gfx_split ? '0 : JW'(g_gfx_reg));
    assign gfx_add = gfx_split ? JW'(g_gfx_reg) : '0;

    always_comb begin
        j_next[0] = JW'(g_user_reg);
        j_next[1] = j_next[0] + JW'(g_sys_reg);
        j_next[2] = j_next[1] + JW'(g_intr_reg);
        j_next[3] = j_next[2] + io_add;
        j_next[4] = j_next[3] + gfx_add;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.grp_en) begin
            g_rest_reg <= GW'(avg[0]) + GW'(avg[3]);
            g_user_reg <= GW'(avg[1]);
            g_sys_reg  <= GW'(avg[2]) + GW'(avg[4]);
            g_intr_reg <= GW'(avg[5]);
            g_io_reg   <= GW'(avg[6]) + GW'(avg[7]) + GW'(avg[8]);
            g_gfx_reg  <= GW'(avg[9]) + GW'(avg[10]);
        end
        if (ctrl.acc_en) begin
            sum_reg <= (sum_raw == '0) ? SW'(1) : sum_raw;
            for (int k = 0; k < NLVL; k++) begin
                j_reg[k] <= j_next[k];
            end
        end
        if (ctrl.num_en) begin
            for (int k = 0; k < NLVL; k++) begin
                num_reg[k] <= (NW'({j_reg[k], 8'd0}) - NW'(j_reg[k])) + NW'(sum_reg >> 1);
            end
        end
    end

    assign num = num_reg;
    assign den = sum_reg;
endmodule
`default_nettype wire

/* hw/rtl/cslm_div.sv */
`default_nettype none
module cslm_div
    import cslm_pkg::*;
(
    input  wire logic          aclk,
    input  wire div_ctrl_t     ctrl,
    input  wire logic [NW-1:0] num,
    input  wire logic [SW-1:0] den,
    output logic      [7:0]    level
);
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] den_reg;
    logic [QW-1:0] q_reg;
    logic          fits;

    assign fits = rem_reg >= den_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg <= num;
            den_reg <= NW'({den, 8'd0});
            q_reg   <= '0;
        end else if (ctrl.step) begin
            if (fits) begin
                rem_reg <= rem_reg - den_reg;
            end
            q_reg   <= {q_reg[QW-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    assign level = q_reg[QW-1] ? 8'hFF : q_reg[7:0];
endmodule
`default_nettype wire
